>>> src/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/fcrd_pkg.sv
// Types and constants shared by the FastCGI record deframer.
package fcrd_pkg;

    // Parser phase within a record.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2,
        PH_HALTED  = 2'd3
    } t_phase;

    // Result kind codes as seen on the output channel.
    typedef enum logic [1:0] {
        KIND_STDOUT       = 2'd0,
        KIND_STDERR       = 2'd1,
        KIND_END_REQUEST  = 2'd2,
        KIND_FORMAT_ERROR = 2'd3
    } t_kind;

    // Header byte positions.
    localparam logic [2:0] HDR_VERSION  = 3'd0;
    localparam logic [2:0] HDR_TYPE     = 3'd1;
    localparam logic [2:0] HDR_ID_HI    = 3'd2;
    localparam logic [2:0] HDR_ID_LO    = 3'd3;
    localparam logic [2:0] HDR_LEN_HI   = 3'd4;
    localparam logic [2:0] HDR_LEN_LO   = 3'd5;
    localparam logic [2:0] HDR_PADDING  = 3'd6;
    localparam logic [2:0] HDR_RESERVED = 3'd7;

    // Protocol values.
    localparam logic [7:0] FCGI_VERSION    = 8'd1;
    localparam logic [7:0] REC_END_REQUEST = 8'd3;
    localparam logic [7:0] REC_STDOUT      = 8'd6;
    localparam logic [7:0] REC_STDERR      = 8'd7;

    // Number of status bytes gathered from an end-request body.
    localparam logic [2:0] STATUS_BYTES = 3'd4;

    // One result transaction.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] record_id;
        logic [31:0] app_status;
        logic        last_content;
    } t_result;

endpackage

>>> src/fcrd_parser.sv
// Record parser: header capture, content/padding counting and result forming.
module fcrd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output fcrd_pkg::t_result   o_result
);

    fcrd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_header_count, n_header_count;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_current_id, n_current_id;
    logic [15:0] r_content_left, n_content_left;
    logic [7:0]  r_padding_left, n_padding_left;
    logic [31:0] r_status_accum, n_status_accum;
    logic [2:0]  r_status_count, n_status_count;

    logic [15:0] content_dec;
    logic [7:0]  padding_dec;
    logic        is_end_req;

    assign content_dec = r_content_left - 16'd1;
    assign padding_dec = r_padding_left - 8'd1;
    assign is_end_req  = (r_type == fcrd_pkg::REC_END_REQUEST);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= fcrd_pkg::PH_HEADER;
            r_header_count <= '0;
            r_version      <= '0;
            r_type         <= '0;
            r_current_id   <= '0;
            r_content_left <= '0;
            r_padding_left <= '0;
            r_status_accum <= '0;
            r_status_count <= '0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_version      <= n_version;
            r_type         <= n_type;
            r_current_id   <= n_current_id;
            r_content_left <= n_content_left;
            r_padding_left <= n_padding_left;
            r_status_accum <= n_status_accum;
            r_status_count <= n_status_count;
        end
    end

    // Next state and result for one byte
    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_version      = r_version;
        n_type         = r_type;
        n_current_id   = r_current_id;
        n_content_left = r_content_left;
        n_padding_left = r_padding_left;
        n_status_accum = r_status_accum;
        n_status_count = r_status_count;

        o_push                = 1'b0;
        o_result.kind         = fcrd_pkg::KIND_STDOUT;
        o_result.payload_byte = '0;
        o_result.record_id    = r_current_id;
        o_result.app_status   = '0;
        o_result.last_content = 1'b0;

        case (r_phase)
            fcrd_pkg::PH_HEADER: begin
                case (r_header_count)
                    fcrd_pkg::HDR_VERSION: n_version = i_byte;
                    fcrd_pkg::HDR_TYPE:    n_type = i_byte;
                    fcrd_pkg::HDR_ID_HI:   n_current_id = {i_byte, 8'd0};
                    fcrd_pkg::HDR_ID_LO:   n_current_id = {r_current_id[15:8], i_byte};
                    fcrd_pkg::HDR_LEN_HI:  n_content_left = {i_byte, 8'd0};
                    fcrd_pkg::HDR_LEN_LO:  n_content_left = {r_content_left[15:8], i_byte};
                    fcrd_pkg::HDR_PADDING: n_padding_left = i_byte;
                    default: ;
                endcase
                if (r_header_count != fcrd_pkg::HDR_RESERVED) begin
                    n_header_count = r_header_count + 3'd1;
                end else begin
                    // Header complete: validate and pick the next phase
                    n_header_count = '0;
                    n_status_accum = '0;
                    n_status_count = '0;
                    if (r_version != fcrd_pkg::FCGI_VERSION ||
                        !(r_type inside {fcrd_pkg::REC_STDOUT, fcrd_pkg::REC_STDERR,
                                         fcrd_pkg::REC_END_REQUEST})) begin
                        n_phase       = fcrd_pkg::PH_HALTED;
                        o_push        = 1'b1;
                        o_result.kind = fcrd_pkg::KIND_FORMAT_ERROR;
                    end else if (r_content_left != '0) begin
                        n_phase = fcrd_pkg::PH_CONTENT;
                    end else if (r_padding_left != '0) begin
                        n_phase = fcrd_pkg::PH_PADDING;
                    end else begin
                        // empty record ends right here
                        n_phase = fcrd_pkg::PH_HEADER;
                        if (is_end_req) begin
                            o_push        = 1'b1;
                            o_result.kind = fcrd_pkg::KIND_END_REQUEST;
                        end
                    end
                end
            end

            fcrd_pkg::PH_CONTENT: begin
                n_content_left = content_dec;
                if (is_end_req) begin
                    // status is gathered big-endian from the first bytes
                    if (r_status_count < fcrd_pkg::STATUS_BYTES) begin
                        n_status_accum = {r_status_accum[23:0], i_byte};
                        n_status_count = r_status_count + 3'd1;
                    end
                    if (content_dec == '0) begin
                        if (r_padding_left != '0) begin
                            n_phase = fcrd_pkg::PH_PADDING;
                        end else begin
                            n_phase             = fcrd_pkg::PH_HEADER;
                            o_push              = 1'b1;
                            o_result.kind       = fcrd_pkg::KIND_END_REQUEST;
                            o_result.app_status = n_status_accum;
                        end
                    end
                end else begin
                    o_push                = 1'b1;
                    o_result.kind         = (r_type == fcrd_pkg::REC_STDERR) ?
                                            fcrd_pkg::KIND_STDERR : fcrd_pkg::KIND_STDOUT;
                    o_result.payload_byte = i_byte;
                    o_result.last_content = (content_dec == '0);
                    if (content_dec == '0) begin
                        n_phase = (r_padding_left != '0) ? fcrd_pkg::PH_PADDING
                                                         : fcrd_pkg::PH_HEADER;
                    end
                end
            end

            fcrd_pkg::PH_PADDING: begin
                n_padding_left = padding_dec;
                if (padding_dec == '0) begin
                    n_phase = fcrd_pkg::PH_HEADER;
                    if (is_end_req) begin
                        o_push              = 1'b1;
                        o_result.kind       = fcrd_pkg::KIND_END_REQUEST;
                        o_result.app_status = r_status_accum;
                    end
                end
            end

            default: ; // halted: bytes are swallowed until reset
        endcase
    end

endmodule

>>> src/fcrd_out_fifo.sv
// Two-entry result queue that decouples the parser from the output stall.
module fcrd_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fcrd_pkg::t_result   i_result,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_stall,
    output fcrd_pkg::t_result   o_result
);

    fcrd_pkg::t_result r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid  = (r_count != 2'd0);
    assign o_space  = (r_count != 2'd2);
    assign pop      = o_valid && !i_stall;
    assign o_result = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_result;
    end

endmodule

>>> src/fastcgi_record_deframer_top.sv
// Top level of the FastCGI record deframer.
//
// Input channel: one stream byte per transaction on i_stream_byte, taken
// when i_valid is high and o_stall is low. Output channel: one result per
// transaction (kind, payload byte, record id, status, last flag), taken
// when o_valid is high and i_stall is low.
// A byte is first held in an input register, then parsed combinationally
// and the result, if any, is written into a two-entry output queue. A result
// is offered on o_valid once it has been written into that queue; the write
// is held back while the queue is full.
// Throughput is one byte per cycle while o_stall is low; the queue lets a new
// byte be parsed while an older result is still waiting to be taken.
// Stdout/stderr content bytes give one result each; an end-request record
// gives one at its last byte; a bad header gives one format error at its last
// byte and the block then swallows all bytes; other bytes give no result.
// When the receiver stalls, the queue fills and o_stall rises once the
// queue is full and the input register holds a byte.
// Synchronous reset (i_rst_n low) returns the parser to the header phase
// and empties the queue and input register.
module fastcgi_record_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_record_id,
    output logic [31:0] o_app_status,
    output logic        o_last_content
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              space;
    logic              fire;
    logic              push;
    fcrd_pkg::t_result parse_result;
    fcrd_pkg::t_result head_result;

    assign fire    = r_in_valid && space;
    assign o_stall = r_in_valid && !space;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_in_byte <= i_stream_byte;
    end

    fcrd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_push   (push),
        .o_result (parse_result)
    );

    fcrd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire && push),
        .i_result (parse_result),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (head_result)
    );

    assign o_kind         = head_result.kind;
    assign o_payload_byte = head_result.payload_byte;
    assign o_record_id    = head_result.record_id;
    assign o_app_status   = head_result.app_status;
    assign o_last_content = head_result.last_content;

endmodule

>>> src/fcrd_checker.sv
// Port-level assertion checker for the deframer, bound to the top level.
`include "assert_macros.svh"

module fcrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [31:0] o_app_status,
    input logic        o_last_content
);

    logic is_data;
    logic is_end;
    logic is_err;
    logic side_clear;

    assign is_data = (o_kind == fcrd_pkg::KIND_STDOUT) || (o_kind == fcrd_pkg::KIND_STDERR);
    assign is_end  = (o_kind == fcrd_pkg::KIND_END_REQUEST);
    assign is_err  = (o_kind == fcrd_pkg::KIND_FORMAT_ERROR);
    assign side_clear = (o_payload_byte == 8'd0) && !o_last_content;

    // Non-data results carry no byte and no last flag
    `ASSERT_IMPLIES(a_nondata_clean, i_clk, i_rst_n, o_valid && !is_data, side_clear)

    // Only end-request results carry a status
    `ASSERT_IMPLIES(a_status_only_end, i_clk, i_rst_n, o_valid && !is_end, o_app_status == 32'd0)

    // A format error is the final result until reset
    `ASSERT_NEXT(a_error_final, i_clk, i_rst_n, o_valid && !i_stall && is_err, !o_valid)

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind))

    // Input stalls only while the output queue holds results
    `ASSERT_IMPLIES(a_stall_full, i_clk, i_rst_n, o_stall, o_valid)

endmodule

bind fastcgi_record_deframer_top fcrd_checker u_fcrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_app_status   (o_app_status),
    .o_last_content (o_last_content)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FastCGI record deframer: directed, random, error halt.
module testbench;

    localparam int RANDOM_BYTES = 280;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 25;
    localparam int DRAIN_CYCLES = 10;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_stream_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_record_id;
    logic [31:0] o_app_status;
    logic        o_last_content;

    fastcgi_record_deframer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_stream_byte  (i_stream_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_record_id    (o_record_id),
        .o_app_status   (o_app_status),
        .o_last_content (o_last_content)
    );

    always #5 i_clk = ~i_clk;

    // One record to send; the typed fields give the record's single result
    typedef struct {
        logic [7:0]      ver;
        logic [7:0]      rtype;
        logic [15:0]     id;
        logic [15:0]     len;
        logic [7:0]      pad;
        logic [7:0]      fill;
        bit              typed;
        fcrd_pkg::t_kind want_kind;
        logic [31:0]     want_status;
    } t_record;

    // Directed records: content byte k is fill + k
    t_record dir_records [10] = '{
        // empty end-request, event on the last header byte
        '{8'd1, fcrd_pkg::REC_END_REQUEST, 16'h0000, 16'd0, 8'd0, 8'h00, 1'b1,
          fcrd_pkg::KIND_END_REQUEST, 32'h0000_0000},
        '{8'd1, fcrd_pkg::REC_STDOUT, 16'hFFFF, 16'd1, 8'd0, 8'h00, 1'b0,
          fcrd_pkg::KIND_STDOUT, 32'h0},
        '{8'd1, fcrd_pkg::REC_STDERR, 16'h8001, 16'd3, 8'd2, 8'hFE, 1'b0,
          fcrd_pkg::KIND_STDOUT, 32'h0},
        '{8'd1, fcrd_pkg::REC_END_REQUEST, 16'h1234, 16'd4, 8'd0, 8'hFC, 1'b1,
          fcrd_pkg::KIND_END_REQUEST, 32'hFCFD_FEFF},
        // short status, event on the last padding byte
        '{8'd1, fcrd_pkg::REC_END_REQUEST, 16'hFFFF, 16'd2, 8'd3, 8'h80, 1'b1,
          fcrd_pkg::KIND_END_REQUEST, 32'h0000_8081},
        // long status body, extra bytes ignored
        '{8'd1, fcrd_pkg::REC_END_REQUEST, 16'h00FF, 16'd6, 8'd0, 8'h01, 1'b1,
          fcrd_pkg::KIND_END_REQUEST, 32'h0102_0304},
        // padding only, long padding
        '{8'd1, fcrd_pkg::REC_STDOUT, 16'h7F00, 16'd0, 8'd32, 8'h00, 1'b0,
          fcrd_pkg::KIND_STDOUT, 32'h0},
        '{8'd1, fcrd_pkg::REC_STDERR, 16'h0100, 16'h0102, 8'd0, 8'h00, 1'b0,
          fcrd_pkg::KIND_STDOUT, 32'h0},
        '{8'd1, fcrd_pkg::REC_STDOUT, 16'h5AA5, 16'd0, 8'd0, 8'h00, 1'b0,
          fcrd_pkg::KIND_STDOUT, 32'h0},
        '{8'd1, fcrd_pkg::REC_END_REQUEST, 16'hA55A, 16'd0, 8'd1, 8'h00, 1'b1,
          fcrd_pkg::KIND_END_REQUEST, 32'h0000_0000}
    };

    // Parser model state
    fcrd_pkg::t_phase  ps_phase;
    logic [2:0]        ps_hdr_idx;
    logic [7:0]        ps_version;
    logic [7:0]        ps_rtype;
    logic [15:0]       ps_id;
    logic [15:0]       ps_body_left;
    logic [7:0]        ps_pad_left;
    logic [31:0]       ps_status;
    logic [2:0]        ps_status_n;
    bit                pred_hit;
    fcrd_pkg::t_result pred_res;

    fcrd_pkg::t_result pending_results [$];
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;
    int          bytes_sent = 0;
    int          records_sent = 0;
    int          results_seen = 0;
    int          end_events = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;

    // Record finished: back to header, end-request gives its event
    task automatic end_record();
        ps_phase = fcrd_pkg::PH_HEADER;
        if (ps_rtype == fcrd_pkg::REC_END_REQUEST) begin
            pred_hit = 1'b1;
            pred_res = '{fcrd_pkg::KIND_END_REQUEST, 8'h00, ps_id, ps_status, 1'b0};
        end
    endtask

    // Content exhausted: skip padding if any
    task automatic close_body();
        if (ps_pad_left != 8'd0)
            ps_phase = fcrd_pkg::PH_PADDING;
        else
            end_record();
    endtask

    // Advance the parser model by one stream byte
    task automatic parse_stream_byte(input logic [7:0] b);
        pred_hit = 1'b0;
        case (ps_phase)
            fcrd_pkg::PH_HEADER: begin
                case (ps_hdr_idx)
                    fcrd_pkg::HDR_VERSION: ps_version = b;
                    fcrd_pkg::HDR_TYPE:    ps_rtype = b;
                    fcrd_pkg::HDR_ID_HI:   ps_id = {b, 8'h00};
                    fcrd_pkg::HDR_ID_LO:   ps_id[7:0] = b;
                    fcrd_pkg::HDR_LEN_HI:  ps_body_left = {b, 8'h00};
                    fcrd_pkg::HDR_LEN_LO:  ps_body_left[7:0] = b;
                    fcrd_pkg::HDR_PADDING: ps_pad_left = b;
                    default: ;
                endcase
                if (ps_hdr_idx != fcrd_pkg::HDR_RESERVED) begin
                    ps_hdr_idx = ps_hdr_idx + 3'd1;
                end else begin
                    ps_hdr_idx = fcrd_pkg::HDR_VERSION;
                    ps_status = 32'h0;
                    ps_status_n = 3'd0;
                    if (ps_version != fcrd_pkg::FCGI_VERSION ||
                        (ps_rtype != fcrd_pkg::REC_STDOUT &&
                         ps_rtype != fcrd_pkg::REC_STDERR &&
                         ps_rtype != fcrd_pkg::REC_END_REQUEST)) begin
                        ps_phase = fcrd_pkg::PH_HALTED;
                        pred_hit = 1'b1;
                        pred_res = '{fcrd_pkg::KIND_FORMAT_ERROR, 8'h00, ps_id, 32'h0, 1'b0};
                    end else if (ps_body_left != 16'd0) begin
                        ps_phase = fcrd_pkg::PH_CONTENT;
                    end else begin
                        close_body();
                    end
                end
            end
            fcrd_pkg::PH_CONTENT: begin
                ps_body_left = ps_body_left - 16'd1;
                if (ps_rtype == fcrd_pkg::REC_END_REQUEST) begin
                    if (ps_status_n < fcrd_pkg::STATUS_BYTES) begin
                        ps_status = {ps_status[23:0], b};
                        ps_status_n = ps_status_n + 3'd1;
                    end
                    if (ps_body_left == 16'd0)
                        close_body();
                end else begin
                    pred_hit = 1'b1;
                    pred_res = '{(ps_rtype == fcrd_pkg::REC_STDERR) ?
                                 fcrd_pkg::KIND_STDERR : fcrd_pkg::KIND_STDOUT,
                                 b, ps_id, 32'h0, ps_body_left == 16'd0};
                    if (ps_body_left == 16'd0)
                        close_body();
                end
            end
            fcrd_pkg::PH_PADDING: begin
                ps_pad_left = ps_pad_left - 8'd1;
                if (ps_pad_left == 8'd0)
                    end_record();
            end
            default: ;
        endcase
    endtask

    // Offer one byte, wait for the transaction, then predict its result
    task automatic put_byte(input logic [7:0] b, input bit typed,
                            input fcrd_pkg::t_result want);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        parse_stream_byte(b);
        if (pred_hit)
            pending_results.push_back(typed ? want : pred_res);
    endtask

    // Send header, content and padding of one record
    task automatic send_record(input t_record r, input bit rand_body);
        fcrd_pkg::t_result want;
        logic [7:0]        hdr [8];
        want = '{r.want_kind, 8'h00, r.id, r.want_status, 1'b0};
        hdr = '{r.ver, r.rtype, r.id[15:8], r.id[7:0], r.len[15:8], r.len[7:0],
                r.pad, 8'($urandom)};
        foreach (hdr[i])
            put_byte(hdr[i], r.typed, want);
        for (int k = 0; k < r.len; k++)
            put_byte(rand_body ? 8'($urandom) : 8'(r.fill + k), r.typed, want);
        for (int k = 0; k < r.pad; k++)
            put_byte(8'($urandom), r.typed, want);
        records_sent++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: result %0d mismatch: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    // Compare one output transaction with the oldest expectation
    task automatic check_result();
        fcrd_pkg::t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d id %h",
                                      o_kind, o_record_id));
        end else begin
            want = pending_results.pop_front();
            if (o_kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
            if (o_payload_byte !== want.payload_byte)
                report_mismatch($sformatf("payload %h, want %h",
                                          o_payload_byte, want.payload_byte));
            if (o_record_id !== want.record_id)
                report_mismatch($sformatf("id %h, want %h", o_record_id, want.record_id));
            if (o_app_status !== want.app_status)
                report_mismatch($sformatf("status %h, want %h",
                                          o_app_status, want.app_status));
            if (o_last_content !== want.last_content)
                report_mismatch($sformatf("last %b, want %b",
                                          o_last_content, want.last_content));
            if (want.kind == fcrd_pkg::KIND_END_REQUEST)
                end_events++;
        end
        results_seen++;
    endtask

    // Output monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (o_valid && !i_stall)
                check_result();
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: random stalls, quiet stretches and one long hold-off
    initial begin
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 32 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT)
                gap = LONG_HOLD;
            else
                gap = recv_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
        end
    end

    // Main stimulus
    initial begin
        t_record r;
        int      dir_bytes;

        ps_phase = fcrd_pkg::PH_HEADER;
        ps_hdr_idx = fcrd_pkg::HDR_VERSION;
        ps_version = 8'h00;
        ps_rtype = 8'h00;
        ps_id = 16'h0;
        ps_body_left = 16'h0;
        ps_pad_left = 8'h00;
        ps_status = 32'h0;
        ps_status_n = 3'd0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed records
        foreach (dir_records[i]) begin
            send_quiet = ($urandom_range(0, 2) == 0);
            send_record(dir_records[i], 1'b0);
        end
        dir_bytes = bytes_sent;

        // random well-formed records, mostly small
        while (bytes_sent < dir_bytes + RANDOM_BYTES) begin
            r.ver = fcrd_pkg::FCGI_VERSION;
            case ($urandom_range(0, 2))
                0:       r.rtype = fcrd_pkg::REC_STDOUT;
                1:       r.rtype = fcrd_pkg::REC_STDERR;
                default: r.rtype = fcrd_pkg::REC_END_REQUEST;
            endcase
            r.id = 16'($urandom);
            if (r.rtype == fcrd_pkg::REC_END_REQUEST)
                r.len = 16'($urandom_range(0, 7));
            else if ($urandom_range(0, 19) == 0)
                r.len = 16'($urandom_range(13, 40));
            else
                r.len = 16'($urandom_range(0, 12));
            if ($urandom_range(0, 9) == 0)
                r.pad = 8'($urandom_range(8, 31));
            else
                r.pad = 8'($urandom_range(0, 7));
            r.fill = 8'h00;
            r.typed = 1'b0;
            r.want_kind = fcrd_pkg::KIND_STDOUT;
            r.want_status = 32'h0;
            send_quiet = ($urandom_range(0, 3) == 0);
            send_record(r, 1'b1);
        end

        // bad header: one format error, then the block halts
        r.id = 16'($urandom);
        r.len = 16'($urandom_range(0, 4));
        r.pad = 8'($urandom_range(0, 3));
        r.typed = 1'b1;
        r.want_kind = fcrd_pkg::KIND_FORMAT_ERROR;
        r.want_status = 32'h0;
        if ($urandom_range(0, 1) == 0) begin
            do r.ver = 8'($urandom); while (r.ver == fcrd_pkg::FCGI_VERSION);
            r.rtype = 8'($urandom);
        end else begin
            r.ver = fcrd_pkg::FCGI_VERSION;
            do r.rtype = 8'($urandom);
            while (r.rtype == fcrd_pkg::REC_STDOUT || r.rtype == fcrd_pkg::REC_STDERR ||
                   r.rtype == fcrd_pkg::REC_END_REQUEST);
        end
        send_record(r, 1'b1);

        // a valid-looking record after the halt must be swallowed
        r.ver = fcrd_pkg::FCGI_VERSION;
        r.rtype = fcrd_pkg::REC_STDOUT;
        r.len = 16'd6;
        r.pad = 8'd2;
        r.typed = 1'b0;
        send_record(r, 1'b1);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d stream bytes in %0d records; %0d results checked, %0d end events.",
                 bytes_sent, records_sent, results_seen, end_events);
        $display("Included edge headers, random idling, a long output hold and a format halt.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/fcrd_pkg.sv
src/fcrd_parser.sv
src/fcrd_out_fifo.sv
src/fastcgi_record_deframer_top.sv
src/fcrd_checker.sv
tb/testbench.sv
